// ----- rtl/mpd_pkg.sv -----
// Shared constants and types for the max pooling downscaler.
// Used by max_pool_downscale and its port checker; depends on nothing.
package mpd_pkg;

	localparam int SAMPLE_BITS = 16;
	localparam int MAX_HEIGHT  = 1024;
	localparam int SLOT_W      = $clog2(MAX_HEIGHT);
	localparam int HEIGHT_W    = 11;
	localparam int WIDTH_W     = 16;
	localparam int POOL_W      = 11;
	localparam int PADDR_W     = 4;
	localparam int FIFO_DEPTH  = 4;
	localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);

	// register indexes, byte address is 4 * index
	localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd0;
	localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd1;
	localparam logic [1:0] REG_POOL_ROWS    = 2'd2;
	localparam logic [1:0] REG_POOL_COLS    = 2'd3;

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;

	typedef struct packed {
		logic    image_done;
		sample_t pooled_value;
	} out_word_t;

endpackage

// ----- rtl/max_pool_downscale.sv -----
// Streaming 2-D max pooling, non-overlapping windows, partial edge windows.
// A pooled word passes through stage 1 and then the output queue before it shows on m_tvalid.
// Throughput: one pixel per cycle, one read-modify-write of the maxima RAM each;
// a stalled output backs up through a four-word queue before s_tready drops.
// Reset (arst_n low, asynchronous): counters, queue and pipeline clear; registers
// return to height 1, width 1, pool 2 x 2; the maxima RAM holds whatever it had.
module max_pool_downscale (
	input  logic                              clk,
	input  logic                              arst_n,
	// pixel stream in
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [mpd_pkg::SAMPLE_BITS-1:0]   s_tdata,   // [15:0] pixel_value
	// pooled stream out
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [mpd_pkg::SAMPLE_BITS-1:0]   m_tdata,   // [15:0] pooled_value
	output logic                              m_tlast,   // image_done
	// configuration
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [mpd_pkg::PADDR_W-1:0]       paddr,
	input  logic [31:0]                       pwdata,
	output logic [31:0]                       prdata,
	output logic                              pready
);

	// configuration registers
	logic [mpd_pkg::HEIGHT_W-1:0] image_height_q;
	logic [mpd_pkg::WIDTH_W-1:0]  image_width_q;
	logic [mpd_pkg::POOL_W-1:0]   pool_rows_q;
	logic [mpd_pkg::POOL_W-1:0]   pool_cols_q;

	// position counters
	logic [mpd_pkg::SLOT_W-1:0]   row_pos_q;
	logic [mpd_pkg::WIDTH_W-1:0]  col_pos_q;
	logic [mpd_pkg::SLOT_W-1:0]   row_in_win_q;
	logic [mpd_pkg::POOL_W-1:0]   col_in_win_q;
	logic [mpd_pkg::SLOT_W-1:0]   out_row_q;

	// stage 1
	logic                         valid_s1;
	logic                         first_s1;
	logic                         emit_s1;
	logic                         done_s1;
	logic [mpd_pkg::SLOT_W-1:0]   slot_s1;
	mpd_pkg::sample_t             px_s1;
	mpd_pkg::sample_t             rd_data_s1;

	// last write, for same-slot forwarding
	logic                         lw_valid_q;
	logic [mpd_pkg::SLOT_W-1:0]   lw_slot_q;
	mpd_pkg::sample_t             lw_data_q;

	mpd_pkg::sample_t             maxima_mem [mpd_pkg::MAX_HEIGHT];

	// output queue
	mpd_pkg::out_word_t           fifo_q [mpd_pkg::FIFO_DEPTH];
	logic [mpd_pkg::FIFO_PTR_W-1:0] wr_ptr_q;
	logic [mpd_pkg::FIFO_PTR_W-1:0] rd_ptr_q;
	logic [mpd_pkg::FIFO_PTR_W:0]   cnt_q;

	logic                         cfg_wr;
	logic                         accept;
	logic                         push;
	logic                         pop;

	logic [mpd_pkg::HEIGHT_W-1:0] h_eff;
	logic [mpd_pkg::WIDTH_W-1:0]  w_eff;
	logic [mpd_pkg::POOL_W-1:0]   pr_eff;
	logic [mpd_pkg::POOL_W-1:0]   pc_eff;
	logic                         last_row;
	logic                         last_col;
	logic                         win_row_end;
	logic                         win_col_end;

	mpd_pkg::sample_t             old_max;
	mpd_pkg::sample_t             new_max;
	logic [mpd_pkg::SLOT_W:0]     out_row_inc;

	// ---------------------------------------------------------------- config
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_height_q <= mpd_pkg::HEIGHT_W'(1);
			image_width_q  <= mpd_pkg::WIDTH_W'(1);
			pool_rows_q    <= mpd_pkg::POOL_W'(2);
			pool_cols_q    <= mpd_pkg::POOL_W'(2);
		end else if (cfg_wr) begin
			case (paddr[3:2])
				mpd_pkg::REG_IMAGE_HEIGHT: image_height_q <= pwdata[mpd_pkg::HEIGHT_W-1:0];
				mpd_pkg::REG_IMAGE_WIDTH:  image_width_q  <= pwdata[mpd_pkg::WIDTH_W-1:0];
				mpd_pkg::REG_POOL_ROWS:    pool_rows_q    <= pwdata[mpd_pkg::POOL_W-1:0];
				mpd_pkg::REG_POOL_COLS:    pool_cols_q    <= pwdata[mpd_pkg::POOL_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			mpd_pkg::REG_IMAGE_HEIGHT: prdata = {{(32-mpd_pkg::HEIGHT_W){1'b0}}, image_height_q};
			mpd_pkg::REG_IMAGE_WIDTH:  prdata = {{(32-mpd_pkg::WIDTH_W){1'b0}}, image_width_q};
			mpd_pkg::REG_POOL_ROWS:    prdata = {{(32-mpd_pkg::POOL_W){1'b0}}, pool_rows_q};
			mpd_pkg::REG_POOL_COLS:    prdata = {{(32-mpd_pkg::POOL_W){1'b0}}, pool_cols_q};
			default:                   prdata = '0;
		endcase
	end

	// ------------------------------------------------------- position logic
	always_comb begin
		// zero acts as one, height saturates at the buffer depth
		h_eff  = (image_height_q == '0) ? mpd_pkg::HEIGHT_W'(1) : image_height_q;
		if (h_eff > mpd_pkg::HEIGHT_W'(mpd_pkg::MAX_HEIGHT))
			h_eff = mpd_pkg::HEIGHT_W'(mpd_pkg::MAX_HEIGHT);
		w_eff  = (image_width_q == '0) ? mpd_pkg::WIDTH_W'(1) : image_width_q;
		pr_eff = (pool_rows_q == '0) ? mpd_pkg::POOL_W'(1) : pool_rows_q;
		pc_eff = (pool_cols_q == '0) ? mpd_pkg::POOL_W'(1) : pool_cols_q;

		last_row    = ({1'b0, row_pos_q} + 11'd1) >= h_eff;
		last_col    = ({1'b0, col_pos_q} + 17'd1) >= {1'b0, w_eff};
		win_row_end = last_row || (({1'b0, row_in_win_q} + 11'd1) >= pr_eff);
		win_col_end = last_col || (({1'b0, col_in_win_q} + 12'd1) >= {1'b0, pc_eff});
		out_row_inc = {1'b0, out_row_q} + 1'b1;
	end

	// hold the input while the queue could overflow
	assign s_tready = ({1'b0, cnt_q} + {{(mpd_pkg::FIFO_PTR_W+1){1'b0}}, valid_s1 && emit_s1})
	                  < (mpd_pkg::FIFO_PTR_W+2)'(mpd_pkg::FIFO_DEPTH);
	assign accept   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_pos_q    <= '0;
			col_pos_q    <= '0;
			row_in_win_q <= '0;
			col_in_win_q <= '0;
			out_row_q    <= '0;
		end else if (accept) begin
			if (last_row) begin
				row_pos_q    <= '0;
				row_in_win_q <= '0;
				out_row_q    <= '0;
				if (last_col) begin
					col_pos_q    <= '0;
					col_in_win_q <= '0;
				end else begin
					col_pos_q    <= col_pos_q + 1'b1;
					col_in_win_q <= win_col_end ? '0 : col_in_win_q + 1'b1;
				end
			end else begin
				row_pos_q <= row_pos_q + 1'b1;
				if (win_row_end) begin
					row_in_win_q <= '0;
					// saturate at the last slot
					out_row_q <= out_row_inc[mpd_pkg::SLOT_W] ? out_row_q
					                                          : out_row_inc[mpd_pkg::SLOT_W-1:0];
				end else begin
					row_in_win_q <= row_in_win_q + 1'b1;
				end
			end
		end
	end

	// ------------------------------------------------------- stage 1 + RAM
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1   <= 1'b0;
			lw_valid_q <= 1'b0;
		end else begin
			valid_s1   <= accept;
			lw_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			first_s1 <= (col_in_win_q == '0) && (row_in_win_q == '0);
			emit_s1  <= win_row_end && win_col_end;
			done_s1  <= last_row && last_col;
			slot_s1  <= out_row_q;
			px_s1    <= s_tdata;
		end
		lw_slot_q <= slot_s1;
		lw_data_q <= new_max;
	end

	// read-before-write; the write landing on the read edge is forwarded
	always_ff @(posedge clk) begin
		if (valid_s1)
			maxima_mem[slot_s1] <= new_max;
		if (accept)
			rd_data_s1 <= maxima_mem[out_row_q];
	end

	always_comb begin
		old_max = (lw_valid_q && (lw_slot_q == slot_s1)) ? lw_data_q : rd_data_s1;
		new_max = (first_s1 || (px_s1 > old_max)) ? px_s1 : old_max;
	end

	// ---------------------------------------------------------- output queue
	assign push     = valid_s1 && emit_s1;
	assign m_tvalid = (cnt_q != '0);
	assign pop      = m_tvalid && m_tready;
	assign m_tdata  = fifo_q[rd_ptr_q].pooled_value;
	assign m_tlast  = fifo_q[rd_ptr_q].image_done;

	always_ff @(posedge clk) begin
		if (push)
			fifo_q[wr_ptr_q] <= '{image_done: done_s1, pooled_value: new_max};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ----- rtl/mpd_checker.sv -----
// Port-level checks for max_pool_downscale, bound to the top level.
// Depends on mpd_pkg for port widths.
module mpd_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              s_tvalid,
	input logic                              s_tready,
	input logic                              m_tvalid,
	input logic                              m_tready,
	input logic [mpd_pkg::SAMPLE_BITS-1:0]   m_tdata,
	input logic                              m_tlast,
	input logic                              psel,
	input logic                              penable,
	input logic                              pready
);

	// a stalled output word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("output word changed while stalled");

	// input backpressure only while output words are queued
	a_ready_backup: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid)
		else $error("input stalled with empty output");

	// a new output word follows an accepted pixel through stage 1 and the output queue
	a_out_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
		else $error("output word without matching pixel");

	// config port never waits
	a_pready: assert property (@(posedge clk) disable iff (!arst_n)
		psel && penable |-> pready)
		else $error("config access stalled");

endmodule

bind max_pool_downscale mpd_checker u_mpd_checker (.*);

// ----- test/tb.sv -----
// Testbench for max_pool_downscale: streams pixels in column-major order and checks every
// pooled word against a cycle-free predictor of the pooling windows kept in a small class.
// Depends on mpd_pkg and max_pool_downscale from the rtl folder.
`timescale 1ns / 100ps

module tb;

	localparam int RESET_CYCLES = 6;
	localparam int IDLE_CYCLES = 8;
	localparam int HOLD_CYCLES = 300;
	localparam int QUIET_LIMIT = 3000;
	localparam int RANDOM_PIXELS = 620;
	localparam int PAD_LIMIT = 40;

	// running maxima per output row, expected pooled words in arrival order
	class max_pool_tracker;
		bit [mpd_pkg::HEIGHT_W-1:0] height;
		bit [mpd_pkg::WIDTH_W-1:0]  width;
		bit [mpd_pkg::POOL_W-1:0]   pool_rows;
		bit [mpd_pkg::POOL_W-1:0]   pool_cols;
		mpd_pkg::sample_t           band_max[mpd_pkg::MAX_HEIGHT];
		int                         row_pos;
		int                         col_pos;
		int                         row_in_win;
		int                         col_in_win;
		int                         out_row;
		mpd_pkg::out_word_t         pooled_due[$];
		int                         errors;

		function new();
			height = 1;
			width = 1;
			pool_rows = 2;
			pool_cols = 2;
			foreach (band_max[i])
				band_max[i] = '0;
			row_pos = 0;
			col_pos = 0;
			row_in_win = 0;
			col_in_win = 0;
			out_row = 0;
			errors = 0;
		endfunction

		function bit [31:0] reg_mask(logic [1:0] idx);
			case (idx)
			mpd_pkg::REG_IMAGE_HEIGHT: return (32'd1 << mpd_pkg::HEIGHT_W) - 1;
			mpd_pkg::REG_IMAGE_WIDTH:  return (32'd1 << mpd_pkg::WIDTH_W) - 1;
			default:                   return (32'd1 << mpd_pkg::POOL_W) - 1;
			endcase
		endfunction

		function bit [31:0] reg_value(logic [1:0] idx);
			case (idx)
			mpd_pkg::REG_IMAGE_HEIGHT: return 32'(height);
			mpd_pkg::REG_IMAGE_WIDTH:  return 32'(width);
			mpd_pkg::REG_POOL_ROWS:    return 32'(pool_rows);
			default:                   return 32'(pool_cols);
			endcase
		endfunction

		function void write_reg(logic [1:0] idx, logic [31:0] data);
			case (idx)
			mpd_pkg::REG_IMAGE_HEIGHT: height = data[mpd_pkg::HEIGHT_W-1:0];
			mpd_pkg::REG_IMAGE_WIDTH:  width = data[mpd_pkg::WIDTH_W-1:0];
			mpd_pkg::REG_POOL_ROWS:    pool_rows = data[mpd_pkg::POOL_W-1:0];
			default:                   pool_cols = data[mpd_pkg::POOL_W-1:0];
			endcase
		endfunction

		static function int at_least_one(int v);
			return v == 0 ? 1 : v;
		endfunction

		// pixels left until a band of window columns starts fresh at row 0
		function int pixels_to_band_start();
			int h;
			int w;
			int pc;
			int cols;
			h = at_least_one(height);
			if (h > mpd_pkg::MAX_HEIGHT)
				h = mpd_pkg::MAX_HEIGHT;
			w = at_least_one(width);
			pc = at_least_one(pool_cols);
			if (row_pos == 0 && col_in_win == 0)
				return 0;
			cols = pc - col_in_win;
			if (w - col_pos < cols)
				cols = w - col_pos;
			if (cols < 1)
				cols = 1;
			return (h - row_pos) + (cols - 1) * h;
		endfunction

		function void take_pixel(mpd_pkg::sample_t px);
			int                 h;
			int                 w;
			int                 pr;
			int                 pc;
			int                 slot;
			bit                 last_row;
			bit                 last_col;
			bit                 row_end;
			bit                 col_end;
			mpd_pkg::out_word_t word;
			h = at_least_one(height);
			if (h > mpd_pkg::MAX_HEIGHT)
				h = mpd_pkg::MAX_HEIGHT;
			w = at_least_one(width);
			pr = at_least_one(pool_rows);
			pc = at_least_one(pool_cols);
			last_row = row_pos + 1 >= h;
			last_col = col_pos + 1 >= w;
			row_end = last_row || row_in_win + 1 >= pr;
			col_end = last_col || col_in_win + 1 >= pc;
			slot = out_row < mpd_pkg::MAX_HEIGHT ? out_row : mpd_pkg::MAX_HEIGHT - 1;
			// open the window on its first pixel, else keep the larger sample
			if ((col_in_win == 0 && row_in_win == 0) || px > band_max[slot])
				band_max[slot] = px;
			if (row_end && col_end) begin
				word.pooled_value = band_max[slot];
				word.image_done = last_row && last_col;
				pooled_due.push_back(word);
			end
			if (row_end) begin
				row_in_win = 0;
				out_row++;
			end else
				row_in_win++;
			if (last_row) begin
				row_pos = 0;
				row_in_win = 0;
				out_row = 0;
				col_in_win = col_end ? 0 : col_in_win + 1;
				if (last_col) begin
					col_pos = 0;
					col_in_win = 0;
				end else
					col_pos++;
			end else
				row_pos++;
			if (out_row >= mpd_pkg::MAX_HEIGHT)
				out_row = mpd_pkg::MAX_HEIGHT - 1;
		endfunction

		function void match_word(logic [mpd_pkg::SAMPLE_BITS-1:0] data, logic last);
			mpd_pkg::out_word_t want;
			if (pooled_due.size() == 0) begin
				$error("pooled_value: no word due, actual %0d", $signed(data));
				errors++;
				return;
			end
			want = pooled_due.pop_front();
			if (data !== want.pooled_value) begin
				$error("pooled_value: expected %0d actual %0d", want.pooled_value, $signed(data));
				errors++;
			end
			if (last !== want.image_done) begin
				$error("image_done: expected %0d actual %0d", want.image_done, last);
				errors++;
			end
		endfunction
	endclass

	logic                            clk;
	logic                            arst_n;
	logic                            s_tvalid;
	logic                            s_tready;
	logic [mpd_pkg::SAMPLE_BITS-1:0] s_tdata;
	logic                            m_tvalid;
	logic                            m_tready;
	logic [mpd_pkg::SAMPLE_BITS-1:0] m_tdata;
	logic                            m_tlast;
	logic                            psel;
	logic                            penable;
	logic                            pwrite;
	logic [mpd_pkg::PADDR_W-1:0]     paddr;
	logic [31:0]                     pwdata;
	logic [31:0]                     prdata;
	logic                            pready;

	max_pool_tracker tracker = new();

	bit src_busy;
	bit sink_busy;
	bit hold_req;
	int stall_left;
	int quiet;

	mpd_pkg::sample_t edge_values[8] = '{32767, -32768, 0, -1, 1, -32767, 32766, 2};
	logic [1:0]       reg_list[4] = '{mpd_pkg::REG_IMAGE_HEIGHT, mpd_pkg::REG_IMAGE_WIDTH,
	                                  mpd_pkg::REG_POOL_ROWS, mpd_pkg::REG_POOL_COLS};

	max_pool_downscale dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	// mostly short gaps, a few long ones
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 19);
		if (r < 14)
			return $urandom_range(1, 3);
		else if (r < 19)
			return $urandom_range(4, 10);
		return $urandom_range(11, 40);
	endfunction

	function automatic mpd_pkg::sample_t random_pixel();
		int       r;
		bit [31:0] bits;
		r = $urandom_range(0, 9);
		bits = $urandom;
		case (r)
		0: return 32767;
		1: return -32768;
		2: return mpd_pkg::sample_t'(int'($urandom_range(0, 4)) - 2);
		default: return bits[mpd_pkg::SAMPLE_BITS-1:0];
		endcase
	endfunction

	function automatic int unsigned random_setting(logic [1:0] idx);
		int          r;
		int unsigned top;
		int unsigned typ;
		r = $urandom_range(0, 99);
		case (idx)
		mpd_pkg::REG_IMAGE_HEIGHT: begin
			top = (1 << mpd_pkg::HEIGHT_W) - 1;
			typ = 12;
		end
		mpd_pkg::REG_IMAGE_WIDTH: begin
			top = (1 << mpd_pkg::WIDTH_W) - 1;
			typ = 8;
		end
		default: begin
			top = (1 << mpd_pkg::POOL_W) - 1;
			typ = 4;
		end
		endcase
		if (r < 5)
			return 0;
		else if (r < 10)
			return (idx == mpd_pkg::REG_IMAGE_HEIGHT && r < 7) ? mpd_pkg::MAX_HEIGHT : top;
		else if (r < 20)
			return $urandom_range(0, top);
		return $urandom_range(1, typ);
	endfunction

	// predict on accepted pixels first, then check accepted words; count quiet cycles
	always @(posedge clk) begin
		if (s_tvalid && s_tready)
			tracker.take_pixel(s_tdata);
		if (m_tvalid && m_tready)
			tracker.match_word(m_tdata, m_tlast);
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
				(psel && penable && pready))
			quiet = 0;
		else if (++quiet >= QUIET_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// output side: random stalls, one long hold-off on request
	initial begin
		m_tready = 1'b0;
		stall_left = 0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				m_tready = 1'b0;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
				hold_req = 1'b0;
			end else if (stall_left > 0) begin
				m_tready = 1'b0;
				stall_left--;
			end else if (!sink_busy || $urandom_range(0, 3) != 0)
				m_tready = 1'b1;
			else begin
				m_tready = 1'b0;
				stall_left = pick_gap() - 1;
			end
		end
	end

	task automatic send_pixel(mpd_pkg::sample_t px);
		int gap;
		gap = (src_busy && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
		if (gap > 0) begin
			@(negedge clk);
			s_tvalid = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		s_tvalid = 1'b1;
		s_tdata = px;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic run_pixels(int count, bit from_edges, int ofs);
		for (int i = 0; i < count; i++)
			send_pixel(from_edges ? edge_values[(i + ofs) % 8] : random_pixel());
		@(negedge clk);
		s_tvalid = 1'b0;
	endtask

	// wait for every due word, then let the pipeline empty of words that make no result
	task automatic settle();
		while (tracker.pooled_due.size() != 0)
			@(posedge clk);
		repeat (IDLE_CYCLES) @(posedge clk);
	endtask

	task automatic apb_transfer(logic [1:0] idx, logic write, logic [31:0] data,
			output logic [31:0] rd);
		@(negedge clk);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = write;
		paddr = {idx, 2'b00};
		pwdata = data;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		rd = prdata;
		if (write)
			tracker.write_reg(idx, data);
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	// write with junk in the unused upper bits, then read back
	task automatic set_reg(logic [1:0] idx, int unsigned value);
		logic [31:0] mask;
		logic [31:0] data;
		logic [31:0] rd;
		mask = tracker.reg_mask(idx);
		data = ($urandom & ~mask) | (value & mask);
		apb_transfer(idx, 1'b1, data, rd);
		apb_transfer(idx, 1'b0, '0, rd);
		if (rd !== tracker.reg_value(idx)) begin
			$error("prdata: expected %0d actual %0d", tracker.reg_value(idx), rd);
			tracker.errors++;
		end
	endtask

	initial begin
		int sent;
		int n;
		int pad;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		src_busy = 1'b1;
		sink_busy = 1'b1;
		hold_req = 1'b0;
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n = 1'b1;

		// reset settings: one-pixel images, every pixel is its own word
		run_pixels(4, 1'b1, 0);
		settle();
		set_reg(mpd_pkg::REG_IMAGE_HEIGHT, 3);
		set_reg(mpd_pkg::REG_IMAGE_WIDTH, 3);
		set_reg(mpd_pkg::REG_POOL_ROWS, 2);
		set_reg(mpd_pkg::REG_POOL_COLS, 2);
		run_pixels(9, 1'b1, 3);
		settle();
		// zero sizes act as one
		foreach (reg_list[i])
			set_reg(reg_list[i], 0);
		run_pixels(3, 1'b1, 5);
		settle();
		// windows far larger than the image
		set_reg(mpd_pkg::REG_IMAGE_HEIGHT, 5);
		set_reg(mpd_pkg::REG_IMAGE_WIDTH, 2);
		set_reg(mpd_pkg::REG_POOL_ROWS, 2047);
		set_reg(mpd_pkg::REG_POOL_COLS, 2047);
		run_pixels(10, 1'b1, 1);
		settle();
		// widest image, then shrink it mid-image so the column wraps
		set_reg(mpd_pkg::REG_IMAGE_HEIGHT, 1);
		set_reg(mpd_pkg::REG_IMAGE_WIDTH, 65535);
		set_reg(mpd_pkg::REG_POOL_ROWS, 1);
		set_reg(mpd_pkg::REG_POOL_COLS, 1);
		run_pixels(6, 1'b1, 2);
		settle();
		set_reg(mpd_pkg::REG_IMAGE_WIDTH, 3);
		run_pixels(4, 1'b1, 6);
		settle();

		// back up the output queue until the input stalls
		set_reg(mpd_pkg::REG_IMAGE_HEIGHT, 4);
		set_reg(mpd_pkg::REG_IMAGE_WIDTH, 16);
		src_busy = 1'b0;
		hold_req = 1'b1;
		run_pixels(40, 1'b0, 0);
		src_busy = 1'b1;

		sent = 0;
		while (sent < RANDOM_PIXELS) begin
			settle();
			// change settings only where a band starts, so every slot read was written
			pad = tracker.pixels_to_band_start();
			if (pad <= PAD_LIMIT) begin
				if (pad > 0) begin
					run_pixels(pad, 1'b0, 0);
					sent += pad;
					settle();
				end
				foreach (reg_list[i])
					if ($urandom_range(0, 1))
						set_reg(reg_list[i], random_setting(reg_list[i]));
			end
			src_busy = $urandom_range(0, 3) != 0;
			sink_busy = $urandom_range(0, 3) != 0;
			n = $urandom_range(4, 60);
			run_pixels(n, 1'b0, 0);
			sent += n;
		end

		settle();
		if (tracker.errors == 0 && tracker.pooled_due.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

// ----- files.f -----
rtl/mpd_pkg.sv
rtl/max_pool_downscale.sv
rtl/mpd_checker.sv
test/tb.sv
